/* rtl/core/mbe_pkg.sv */
// Package for the Mandelbrot escape-time core: widths, constants, types.
package mbe_pkg;

  // Fixed-point format of the complex plane (signed Q4.28)
  localparam int FRAC_BITS = 28;
  localparam int REG_W     = 32;   // origin registers
  localparam int STEP_W    = 31;   // pixel step register
  localparam int PIX_W     = 12;   // pixel column / row
  localparam int CNT_OUT_W = 9;    // escape count field
  localparam int MAX_DIM   = 4096; // frame size limit, larger indexes saturate

  localparam int DEF_MAX_ITER = 256;

  // Datapath widths
  localparam int MAG_W   = FRAC_BITS + 1;     // |z part| < 2^MAG_W when squared
  localparam int ZS_W    = MAG_W + 1;         // signed operand of the squarers
  localparam int PROD_W  = 2 * MAG_W;         // zr^2, zi^2
  localparam int CPROD_W = STEP_W + PIX_W;    // step * pixel index
  localparam int C_W     = CPROD_W + 2;       // origin + step * index
  localparam int Z_W     = C_W + 1;           // c plus a scaled product

  localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(64'd1 << MAG_W);
  localparam logic [PROD_W:0] FOUR = (PROD_W + 1)'(64'd1 << (2 * FRAC_BITS + 2));

  // Configuration
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_RE  = 2'd0,
    CFG_ORIGIN_IM  = 2'd1,
    CFG_PIXEL_STEP = 2'd2
  } cfg_idx_e;

  localparam logic signed [REG_W-1:0] ORIGIN_RE_RST  = 32'shE000_0000;
  localparam logic signed [REG_W-1:0] ORIGIN_IM_RST  = 32'shF000_0000;
  localparam logic [STEP_W-1:0]       PIXEL_STEP_RST = 31'd1048576;

  // Controller
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic cap;       // capture pixel indexes
    logic load;      // form c, z = c, count = 1
    logic mul;       // register squares and cross product
    logic upd;       // z = z^2 + c, count++
    logic res_load;  // move count into the result register
  } dp_cmd_t;

  typedef struct packed {
    logic big;       // a part of z has magnitude >= 2
    logic at_max;    // count reached the iteration limit
    logic escaped;   // |z|^2 >= 4 from the registered squares
  } dp_sts_t;

endpackage

/* rtl/core/mbe_if.sv */
// Channel interfaces: pixel input, result output, configuration write.
interface mbe_px_if import mbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;

  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface mbe_res_if import mbe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CNT_OUT_W-1:0] escape_count;
  logic                 in_set;

  modport source (output valid, escape_count, in_set, input ready);
  modport sink   (input valid, escape_count, in_set, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [REG_W-1:0]     data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

/* rtl/core/mbe_cfg_regs.sv */
// Configuration registers: origin and pixel step, written over the cfg channel.
module mbe_cfg_regs import mbe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  mbe_cfg_if.sink                  cfg_i,
  output logic signed [REG_W-1:0]  origin_re_o,
  output logic signed [REG_W-1:0]  origin_im_o,
  output logic [STEP_W-1:0]        pixel_step_o
);

  logic signed [REG_W-1:0] origin_re_q, origin_re_d;
  logic signed [REG_W-1:0] origin_im_q, origin_im_d;
  logic [STEP_W-1:0]       pixel_step_q, pixel_step_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    origin_re_d  = origin_re_q;
    origin_im_d  = origin_im_q;
    pixel_step_d = pixel_step_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        CFG_ORIGIN_RE:  origin_re_d  = $signed(cfg_i.data);
        CFG_ORIGIN_IM:  origin_im_d  = $signed(cfg_i.data);
        CFG_PIXEL_STEP: pixel_step_d = cfg_i.data[STEP_W-1:0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_re_q  <= ORIGIN_RE_RST;
      origin_im_q  <= ORIGIN_IM_RST;
      pixel_step_q <= PIXEL_STEP_RST;
    end else begin
      origin_re_q  <= origin_re_d;
      origin_im_q  <= origin_im_d;
      pixel_step_q <= pixel_step_d;
    end
  end

  assign origin_re_o  = origin_re_q;
  assign origin_im_o  = origin_im_q;
  assign pixel_step_o = pixel_step_q;

endmodule

/* rtl/core/mbe_ctrl.sv */
// Controller FSM: sequences load, multiply and update passes, owns the handshakes.
module mbe_ctrl import mbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   res_free;

  assign res_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        if (sts_i.at_max || sts_i.big) state_d = ST_FIN;
        else                           state_d = ST_UPD;
      end
      ST_UPD: begin
        if (sts_i.escaped) state_d = ST_FIN;
        else               state_d = ST_MUL;
      end
      ST_FIN: if (res_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      ST_LOAD: cmd_o.load = 1'b1;
      ST_MUL:  cmd_o.mul  = !(sts_i.at_max || sts_i.big);
      ST_UPD:  cmd_o.upd  = !sts_i.escaped;
      ST_FIN:  cmd_o.res_load = res_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/mbe_datapath.sv */
// Datapath: point setup, two squarers and a cross multiplier, z update, escape test, result register.
module mbe_datapath import mbe_pkg::*; #(
  parameter int MAX_ITER = DEF_MAX_ITER
) (
  input  logic                     clk_i,
  input  logic [PIX_W-1:0]         pixel_col_i,
  input  logic [PIX_W-1:0]         pixel_row_i,
  input  logic signed [REG_W-1:0]  origin_re_i,
  input  logic signed [REG_W-1:0]  origin_im_i,
  input  logic [STEP_W-1:0]        pixel_step_i,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  output logic [CNT_OUT_W-1:0]     escape_count_o,
  output logic                     in_set_o
);

  localparam int CNT_W = $clog2(MAX_ITER + 1);

  logic [PIX_W-1:0]         col_q, row_q, col_sat, row_sat;
  logic signed [C_W-1:0]    c_re_q, c_im_q, c_re_nx, c_im_nx;
  logic [CPROD_W-1:0]       prod_re, prod_im;
  logic signed [Z_W-1:0]    zr_q, zi_q, zr_nx, zi_nx;
  logic signed [ZS_W-1:0]   zr_s, zi_s;
  logic signed [2*ZS_W-1:0] rr_full, ii_full, ri_full;
  logic [PROD_W-1:0]        rr_q, ii_q;
  logic signed [PROD_W:0]   ri_q;
  logic [PROD_W:0]          mag_sum;
  logic signed [PROD_W:0]   diff, diff_sh;
  logic signed [PROD_W+1:0] cross2, cross_sh;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_OUT_W-1:0]     res_count_q;
  logic                     res_in_set_q;

  // indexes beyond the frame saturate to its last pixel
  assign col_sat = ({20'd0, pixel_col_i} > 32'(MAX_DIM - 1)) ? PIX_W'(MAX_DIM - 1) : pixel_col_i;
  assign row_sat = ({20'd0, pixel_row_i} > 32'(MAX_DIM - 1)) ? PIX_W'(MAX_DIM - 1) : pixel_row_i;

  // c = origin + step * index, exact
  assign prod_re = CPROD_W'(pixel_step_i) * CPROD_W'(col_q);
  assign prod_im = CPROD_W'(pixel_step_i) * CPROD_W'(row_q);
  assign c_re_nx = C_W'(origin_re_i) + $signed({2'b00, prod_re});
  assign c_im_nx = C_W'(origin_im_i) + $signed({2'b00, prod_im});

  // squarers only ever see |z part| < 2, so the low bits carry the value
  assign zr_s    = zr_q[ZS_W-1:0];
  assign zi_s    = zi_q[ZS_W-1:0];
  assign rr_full = zr_s * zr_s;
  assign ii_full = zi_s * zi_s;
  assign ri_full = zr_s * zi_s;

  // update from registered products; >>> gives floor toward minus infinity
  assign mag_sum  = {1'b0, rr_q} + {1'b0, ii_q};
  assign diff     = $signed({1'b0, rr_q}) - $signed({1'b0, ii_q});
  assign diff_sh  = diff >>> FRAC_BITS;
  assign cross2   = $signed({ri_q, 1'b0});
  assign cross_sh = cross2 >>> FRAC_BITS;
  assign zr_nx    = Z_W'(diff_sh) + Z_W'(c_re_q);
  assign zi_nx    = Z_W'(cross_sh) + Z_W'(c_im_q);

  assign sts_o.big     = (zr_q >= Z_LIM) || (zr_q <= -Z_LIM) ||
                         (zi_q >= Z_LIM) || (zi_q <= -Z_LIM);
  assign sts_o.at_max  = (count_q == CNT_W'(MAX_ITER));
  assign sts_o.escaped = (mag_sum >= FOUR);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      col_q <= col_sat;
      row_q <= row_sat;
    end
    if (cmd_i.load) begin
      c_re_q  <= c_re_nx;
      c_im_q  <= c_im_nx;
      zr_q    <= Z_W'(c_re_nx);
      zi_q    <= Z_W'(c_im_nx);
      count_q <= CNT_W'(1);
    end else if (cmd_i.upd) begin
      zr_q    <= zr_nx;
      zi_q    <= zi_nx;
      count_q <= count_q + CNT_W'(1);
    end
    if (cmd_i.mul) begin
      rr_q <= rr_full[PROD_W-1:0];
      ii_q <= ii_full[PROD_W-1:0];
      ri_q <= ri_full[PROD_W:0];
    end
    if (cmd_i.res_load) begin
      res_count_q  <= CNT_OUT_W'(count_q);
      res_in_set_q <= sts_o.at_max;
    end
  end

  assign escape_count_o = res_count_q;
  assign in_set_o       = res_in_set_q;

endmodule

/* rtl/core/mandelbrot_escape_time_core.sv */
// Top level of the Mandelbrot escape-time core.
//
// Usage:
//   px_i  : one beat names a pixel (pixel_col, pixel_row). The point is
//           c = origin + pixel_step * (col, row) in signed Q4.28.
//   res_o : one beat per pixel: escape_count (iterations run, 1..MAX_ITER,
//           low 9 bits) and in_set (count hit MAX_ITER).
//   cfg_i : register writes, index 0 origin_re, 1 origin_im, 2 pixel_step;
//           other indexes are dropped. Write only while the core is idle.
// Sequencing:
//   Each iteration is one multiply pass (two squarers and a cross
//   multiplier into registers) followed by one update pass (escape test
//   and z = z^2 + c). One pixel is in flight at a time; px_i is ready
//   again the cycle after its result is loaded.
// Reset: rst_ni clears the controller and loads the default view
//   (origin -2 - 1i, step 1/256). No clearing pass.
// Stall: the result sits in an output register. A new pixel is taken while
//   it waits; that pixel's finished result holds until res_o drains.
module mandelbrot_escape_time_core import mbe_pkg::*; #(
  parameter int MAX_ITER = DEF_MAX_ITER
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbe_px_if.sink     px_i,
  mbe_res_if.source  res_o,
  mbe_cfg_if.sink    cfg_i
);

  logic signed [REG_W-1:0] origin_re, origin_im;
  logic [STEP_W-1:0]       pixel_step;
  dp_cmd_t                 cmd;
  dp_sts_t                 sts;

  mbe_cfg_regs u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .origin_re_o  (origin_re),
    .origin_im_o  (origin_im),
    .pixel_step_o (pixel_step)
  );

  // controller: handshakes and pass sequencing
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (px_i.valid),
    .in_ready_o  (px_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: arithmetic and result register
  mbe_datapath #(
    .MAX_ITER (MAX_ITER)
  ) u_datapath (
    .clk_i          (clk_i),
    .pixel_col_i    (px_i.pixel_col),
    .pixel_row_i    (px_i.pixel_row),
    .origin_re_i    (origin_re),
    .origin_im_i    (origin_im),
    .pixel_step_i   (pixel_step),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .escape_count_o (res_o.escape_count),
    .in_set_o       (res_o.in_set)
  );

endmodule
